>>> rtl/imf_pkg.sv
// ----------------------------------------------------------------------------
// imf_pkg
// Image median filter types: sorter link, control states, register indexes.
// ----------------------------------------------------------------------------
package imf_pkg;

  // one value moving between neighboring sort cells
  typedef struct packed {
    logic       vld;
    logic [7:0] dat;
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_GATHER,
    S_SORT,
    S_OUT
  } state_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KERNEL   = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

endpackage

>>> rtl/imf_ram.sv
// ----------------------------------------------------------------------------
// imf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/imf_sort_cell.sv
// ----------------------------------------------------------------------------
// imf_sort_cell
// Insertion-sort cell: keeps the smallest value seen, passes larger ones on.
// ----------------------------------------------------------------------------
module imf_sort_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clr,
  input  imf_pkg::link_t lin,
  output imf_pkg::link_t lout,
  output logic           hv,
  output logic [7:0]     held
);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      hv       <= 1'b0;
      lout.vld <= 1'b0;
    end else begin
      lout.vld <= lin.vld && hv;
      if (lin.vld) begin
        if (!hv) begin
          held <= lin.dat;
          hv   <= 1'b1;
        end else if (lin.dat < held) begin
          held     <= lin.dat;
          lout.dat <= held;
        end else begin
          lout.dat <= lin.dat;
        end
      end
    end
  end

endmodule

>>> rtl/imf_sorter.sv
// ----------------------------------------------------------------------------
// imf_sorter
// Chain of sort cells; after settling, cell i holds the i-th smallest value.
// ----------------------------------------------------------------------------
module imf_sorter #(
  parameter int CELLS = 49
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  imf_pkg::link_t           lin,
  input  logic [$clog2(CELLS)-1:0] med_idx,
  output logic [7:0]               med_dat,
  output logic                     med_vld
);

  imf_pkg::link_t       chain [CELLS+1];
  logic [CELLS-1:0]     hv;
  logic [7:0]           held [CELLS];

  assign chain[0] = lin;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    imf_sort_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .clr  (clr),
      .lin  (chain[i]),
      .lout (chain[i+1]),
      .hv   (hv[i]),
      .held (held[i])
    );
  end

  assign med_dat = held[med_idx];
  assign med_vld = hv[med_idx];

endmodule

>>> rtl/image_median_filter_top.sv
// ----------------------------------------------------------------------------
// image_median_filter_top
// Streaming 2-D median filter with replicated borders over interleaved bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per channel byte in raster order.
//   s_tuser = 0 carries an image byte in s_tdata, s_tuser = 1 is a drain tick.
//   Output stream (m_*): per-channel window medians in the same order;
//   m_tlast flags the final byte of the image. After the whole image is in,
//   send drain ticks to flush the remaining outputs, one per tick.
//   Configuration (cfg_*): kernel size, width, height, channel count; write
//   only while idle. A write restarts the image; even kernel sizes ignored.
// Timing:
//   Each input transaction passes the update and check states. When it
//   yields an output, its k x k window bytes (k = kernel size) are fetched
//   one per cycle from the line store's single read port and then ripple
//   through the chain of CELLS = MAX_KERNEL^2 sort cells.
//   The median leaves through an output register, so the next input
//   transaction is taken while the result waits; a stalled receiver only
//   blocks once a second result is ready.
// Reset:
//   Synchronous rst restores the default registers (3x3, 1024x480, one
//   channel) and clears the stream counters; line store stays undefined.
// ----------------------------------------------------------------------------
module image_median_filter_top #(
  parameter int MAX_KERNEL   = 7,
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic [0:0]  s_tuser,   // [0] mode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] median
  output logic        m_tlast
);

  // widths
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CHW   = $clog2(MAX_CHANNELS + 1);
  localparam longint TOTAL_MAX = longint'(MAX_WIDTH) * MAX_HEIGHT * MAX_CHANNELS;
  localparam int PW    = $clog2(TOTAL_MAX + 1) + 1;
  localparam int SD    = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(SD);
  localparam int CELLS = MAX_KERNEL * MAX_KERNEL;
  localparam int MW    = $clog2(CELLS);
  localparam int KTOP  = (MAX_KERNEL - 1) | 1;
  localparam int DW    = KW + 1;
  localparam int SYW   = HW + KW + 1;
  localparam int SXW   = WW + KW + 1;
  localparam int TW    = DW + WW + 2;
  localparam int TW2   = TW + CHW + 1;
  localparam int OW    = (TW2 > AW + 2) ? TW2 : AW + 2;
  localparam int CW    = $clog2(CELLS + 8);
  localparam int SETTLE = CELLS + 6;

  // configuration registers
  logic [KW-1:0]  kreg;
  logic [WW-1:0]  wreg;
  logic [HW-1:0]  hreg;
  logic [CHW-1:0] creg;

  // derived products, refreshed every cycle
  logic [WW+CHW-1:0] wc;
  logic [PW-1:0]     total;
  logic [WW+KW:0]    rw;
  logic [PW-1:0]     lag;
  logic [KW-1:0]     rk;
  logic [WW-1:0]     cr;

  // stream counters
  logic [WW-1:0]  icol, ocol;
  logic [HW-1:0]  irow, orow;
  logic [CHW-1:0] ich, och;
  logic [PW-1:0]  rcv, opos;
  logic [AW-1:0]  in_addr, out_addr;
  logic           done;

  imf_pkg::state_t state, state_next;

  // window walk and fetch pipeline
  logic [KW-1:0]          kyi, kxi;
  logic                   va, vb, vc, vd, ve;
  logic signed [DW-1:0]   dy_r, dx_r;
  logic signed [TW-1:0]   t_r;
  logic signed [OW-1:0]   off_r;
  logic [AW-1:0]          raddr;
  logic [7:0]             rdata;
  logic [CW-1:0]          wcnt;
  logic [MW-1:0]          med_idx;
  logic                   sort_clr;
  logic [7:0]             med_dat;
  logic                   med_vld;
  imf_pkg::link_t         sort_in;

  // output register
  logic       out_valid;
  logic [7:0] out_median;
  logic       out_last;

  logic in_acc, ram_we, emit, issue, issue_end, out_load, is_last;
  logic signed [SYW-1:0] sy, sy_cl;
  logic signed [SXW-1:0] sx, sx_cl;
  logic signed [OW:0]    sa;

  assign in_acc    = s_tvalid && s_tready;
  assign ram_we    = in_acc && !s_tuser[0] && !done;
  assign s_tready  = (state == imf_pkg::S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_median;
  assign m_tlast   = out_last;
  assign rk        = kreg >> 1;
  assign emit      = (done || (rcv >= opos + lag + PW'(1))) && (opos < total);
  assign is_last   = (opos + PW'(1) >= total);
  assign issue     = (state == imf_pkg::S_GATHER);
  assign issue_end = issue && (kyi == kreg - KW'(1)) && (kxi == kreg - KW'(1));
  assign out_load  = (state == imf_pkg::S_OUT) && (!out_valid || m_tready);
  assign sort_clr  = (state == imf_pkg::S_CHK);

  // column radius clipped to the row; lag follows a write through rw, then lag
  assign cr = (WW'(rk) < wreg - WW'(1)) ? WW'(rk) : wreg - WW'(1);

  // products for frame size and output lag
  always_ff @(posedge clk) begin
    wc    <= (WW+CHW)'(wreg) * (WW+CHW)'(creg);
    total <= PW'(wc) * PW'(hreg);
    rw    <= (WW+KW+1)'(rk) * (WW+KW+1)'(wreg) + (WW+KW+1)'(cr);
    lag   <= PW'(rw) * PW'(creg);
  end

  // configuration and stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      kreg <= KW'(3);
      wreg <= WW'(MAX_WIDTH);
      hreg <= HW'((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480);
      creg <= CHW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        imf_pkg::REG_KERNEL: begin
          if (cfg_data[0]) begin
            kreg <= (32'(cfg_data[2:0]) > KTOP) ? KW'(KTOP) : KW'(cfg_data[2:0]);
          end
        end
        imf_pkg::REG_WIDTH: begin
          if (cfg_data[10:0] == 11'd0) wreg <= WW'(1);
          else if (32'(cfg_data[10:0]) > MAX_WIDTH) wreg <= WW'(MAX_WIDTH);
          else wreg <= WW'(cfg_data[10:0]);
        end
        imf_pkg::REG_HEIGHT: begin
          if (cfg_data == 13'd0) hreg <= HW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) hreg <= HW'(MAX_HEIGHT);
          else hreg <= HW'(cfg_data);
        end
        imf_pkg::REG_CHANNELS: begin
          if (cfg_data[2:0] == 3'd0) creg <= CHW'(1);
          else if (32'(cfg_data[2:0]) > MAX_CHANNELS) creg <= CHW'(MAX_CHANNELS);
          else creg <= CHW'(cfg_data[2:0]);
        end
        default: ;
      endcase
    end
  end

  wire cfg_restart = cfg_we && !(cfg_index == imf_pkg::REG_KERNEL && !cfg_data[0]);

  always_ff @(posedge clk) begin
    if (rst || cfg_restart || (out_load && is_last)) begin
      icol <= '0; irow <= '0; ich <= '0; rcv <= '0; in_addr <= '0; done <= 1'b0;
      ocol <= '0; orow <= '0; och <= '0; opos <= '0; out_addr <= '0;
    end else begin
      if (ram_we) begin
        rcv     <= rcv + PW'(1);
        in_addr <= (in_addr == AW'(SD - 1)) ? '0 : in_addr + AW'(1);
        if (ich + CHW'(1) >= creg) begin
          ich <= '0;
          if (icol + WW'(1) >= wreg) begin
            icol <= '0;
            if (irow + HW'(1) >= hreg) begin
              irow <= '0;
              done <= 1'b1;
            end else begin
              irow <= irow + HW'(1);
            end
          end else begin
            icol <= icol + WW'(1);
          end
        end else begin
          ich <= ich + CHW'(1);
        end
      end
      if (out_load) begin
        opos     <= opos + PW'(1);
        out_addr <= (out_addr == AW'(SD - 1)) ? '0 : out_addr + AW'(1);
        if (och + CHW'(1) >= creg) begin
          och <= '0;
          if (ocol + WW'(1) >= wreg) begin
            ocol <= '0;
            orow <= orow + HW'(1);
          end else begin
            ocol <= ocol + WW'(1);
          end
        end else begin
          och <= och + CHW'(1);
        end
      end
    end
  end

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) state <= imf_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      imf_pkg::S_IDLE:   if (in_acc) state_next = imf_pkg::S_UPD;
      imf_pkg::S_UPD:    state_next = imf_pkg::S_CHK;
      imf_pkg::S_CHK:    state_next = emit ? imf_pkg::S_GATHER : imf_pkg::S_IDLE;
      imf_pkg::S_GATHER: if (issue_end) state_next = imf_pkg::S_SORT;
      imf_pkg::S_SORT:   if (wcnt == '0) state_next = imf_pkg::S_OUT;
      imf_pkg::S_OUT:    if (out_load) state_next = imf_pkg::S_IDLE;
      default:           state_next = imf_pkg::S_IDLE;
    endcase
  end

  // window walk counters and settle timer
  always_ff @(posedge clk) begin
    if (state == imf_pkg::S_CHK) begin
      kyi     <= '0;
      kxi     <= '0;
      wcnt    <= CW'(SETTLE);
      med_idx <= MW'((32'(kreg) * 32'(kreg)) >> 1);
    end else if (issue) begin
      if (kxi == kreg - KW'(1)) begin
        kxi <= '0;
        kyi <= kyi + KW'(1);
      end else begin
        kxi <= kxi + KW'(1);
      end
    end else if (state == imf_pkg::S_SORT) begin
      wcnt <= wcnt - CW'(1);
    end
  end

  // stage a: clamped tap row and column offsets, and the ring address sum
  always_comb begin
    sy = SYW'(orow) + SYW'(kyi) - SYW'(rk);
    if (sy < 0) sy_cl = '0;
    else if (sy > SYW'(hreg - HW'(1))) sy_cl = SYW'(hreg - HW'(1));
    else sy_cl = sy;
    sx = SXW'(ocol) + SXW'(kxi) - SXW'(rk);
    if (sx < 0) sx_cl = '0;
    else if (sx > SXW'(wreg - WW'(1))) sx_cl = SXW'(wreg - WW'(1));
    else sx_cl = sx;
    sa = (OW+1)'(out_addr) + (OW+1)'(off_r);
    if (sa < 0) sa = sa + (OW+1)'(SD);
    else if (sa >= (OW+1)'(SD)) sa = sa - (OW+1)'(SD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
    end else begin
      va <= issue; vb <= va; vc <= vb; vd <= vc; ve <= vd;
    end
    dy_r  <= DW'(sy_cl - SYW'(orow));
    dx_r  <= DW'(sx_cl - SXW'(ocol));
    // stage b: row offset times width plus column offset
    t_r   <= TW'(dy_r) * TW'($signed({1'b0, wreg})) + TW'(dx_r);
    // stage c: scale by channels
    off_r <= OW'(TW2'(t_r) * TW2'($signed({1'b0, creg})));
    // stage d: ring address
    raddr <= AW'(sa);
  end

  imf_ram #(
    .WIDTH (8),
    .DEPTH (SD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_addr),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sort_in.vld = ve;
  assign sort_in.dat = rdata;

  imf_sorter #(
    .CELLS (CELLS)
  ) u_sorter (
    .clk     (clk),
    .rst     (rst),
    .clr     (sort_clr),
    .lin     (sort_in),
    .med_idx (med_idx),
    .med_dat (med_dat),
    .med_vld (med_vld)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_median <= med_dat;
      out_last   <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == imf_pkg::S_IDLE)
    else $error("line store written outside idle");
  a_median_filled: assert property (@(posedge clk) disable iff (rst)
    state == imf_pkg::S_OUT |-> med_vld)
    else $error("median cell empty at output");
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (out_load && is_last) |=> (opos == '0 && rcv == '0 && !done))
    else $error("counters not cleared after final byte");
  a_rcv_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == imf_pkg::S_CHK) |-> rcv <= total)
    else $error("received count beyond frame size");
`endif

endmodule

>>> bench/image_median_filter_top_tb.sv
// ----------------------------------------------------------------------------
// image_median_filter_top_tb
// Self-checking bench for the streaming 2-D median filter.
// Drives whole images plus drain ticks through the input stream and runs
// them through several frame geometries, kernel sizes and channel counts.
// A behavioral model tracks the line store and window position and predicts
// every median and end-of-image flag; a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module image_median_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXK  = 7;
  localparam int MAXW  = 1024;
  localparam int MAXC  = 4;
  localparam int MAXH  = 4096;
  localparam int DEPTH = MAXK * MAXW * MAXC;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 200;

  // expected output transaction
  typedef struct packed {
    logic [7:0] median;
    logic       last;
  } pix_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the filter model and the queue of pending medians.
  // --------------------------------------------------------------------------
  class median_scoreboard;
    logic [7:0] lines [DEPTH];
    int unsigned ksize, width, height, chans;
    int unsigned in_row, in_col, in_ch, out_row, out_col, out_ch;
    bit          frame_in;
    pix_out_t    pending[$];
    int unsigned errors;

    function void restart();
      in_row = 0; in_col = 0; in_ch = 0;
      out_row = 0; out_col = 0; out_ch = 0;
      frame_in = 0;
    endfunction

    function void init();
      ksize = 3; width = 1024; height = 480; chans = 1;
      errors = 0;
      foreach (lines[i]) lines[i] = '0;
      restart();
    endfunction

    function longint unsigned pos(int unsigned r, int unsigned c, int unsigned ch);
      return (longint'(r) * width + c) * chans + ch;
    endfunction

    function int unsigned clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      int unsigned v;
      case (idx)
        imf_pkg::REG_KERNEL: begin
          v = val[2:0];
          if (v % 2 == 0) return;  // even sizes are dropped
          ksize = (v > MAXK) ? MAXK : v;
        end
        imf_pkg::REG_WIDTH: begin
          v = val[10:0];
          width = (v < 1) ? 1 : (v > MAXW ? MAXW : v);
        end
        imf_pkg::REG_HEIGHT: begin
          v = val[12:0];
          height = (v < 1) ? 1 : (v > MAXH ? MAXH : v);
        end
        imf_pkg::REG_CHANNELS: begin
          v = val[2:0];
          chans = (v < 1) ? 1 : (v > MAXC ? MAXC : v);
        end
        default: return;
      endcase
      restart();
    endfunction

    function logic [7:0] window_median();
      logic [7:0] vals[$];
      int rad;
      int unsigned ny, nx;
      rad = ksize / 2;
      for (int dy = -rad; dy <= rad; dy++) begin
        ny = clip(int'(out_row) + dy, int'(height) - 1);
        for (int dx = -rad; dx <= rad; dx++) begin
          nx = clip(int'(out_col) + dx, int'(width) - 1);
          vals.push_back(lines[pos(ny, nx, out_ch) % DEPTH]);
        end
      end
      vals.sort();
      return vals[vals.size() / 2];
    endfunction

    // accepted input transaction
    function void note_input(logic mode, logic [7:0] sample);
      longint unsigned total, got, opos, lag;
      int unsigned rad, crad;
      pix_out_t e;
      total = longint'(width) * height * chans;
      if (!mode && !frame_in) begin
        lines[pos(in_row, in_col, in_ch) % DEPTH] = sample;
        if (++in_ch >= chans) begin
          in_ch = 0;
          if (++in_col >= width) begin
            in_col = 0;
            if (++in_row >= height) begin
              in_row = 0;
              frame_in = 1;
            end
          end
        end
      end
      got  = frame_in ? total : pos(in_row, in_col, in_ch);
      opos = pos(out_row, out_col, out_ch);
      rad  = ksize / 2;
      crad = (rad < width - 1) ? rad : width - 1;
      lag  = (longint'(rad) * width + crad) * chans;
      if (!frame_in && got < opos + lag + 1) return;
      if (opos >= total) return;
      e.median = window_median();
      e.last   = (opos + 1 >= total);
      pending.push_back(e);
      if (e.last) restart();
      else if (++out_ch >= chans) begin
        out_ch = 0;
        if (++out_col >= width) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    // accepted output transaction
    function void check_output(logic [7:0] median, logic last);
      pix_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output median=%0d last=%0d", $time, median, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (median !== e.median) begin
        $display("%0t: median mismatch expected %0d actual %0d", $time, e.median, median);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] sample
  logic [0:0]  s_tuser = '0;   // [0] mode
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;        // [7:0] median
  logic        m_tlast;

  median_scoreboard sb;
  int  send_idle_pct = 0;   // chance of a sender gap per cycle
  int  recv_stall_pct = 0;  // chance of a receiver stall per cycle
  int  hold_cycles = 0;     // long receiver hold-off, counted down below
  longint cycles = 0;

  image_median_filter_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL image_median_filter_top");
      $finish;
    end
  end

  // output side: sample at the rising edge, pick new ready at the falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction; valid stays up across back-to-back items
  task automatic send_item(logic mode, logic [7:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(mode, sample);
    @(negedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    // a no-result item may still be in flight
    repeat (120) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_geom(int k, int w, int h, int c);
    write_cfg(imf_pkg::REG_KERNEL, 13'(k));
    write_cfg(imf_pkg::REG_WIDTH, 13'(w));
    write_cfg(imf_pkg::REG_HEIGHT, 13'(h));
    write_cfg(imf_pkg::REG_CHANNELS, 13'(c));
  endtask

  // full frame plus drain ticks; pixel style: 0 random, 1 extremes
  task automatic send_frame(int style, int extra_px, int stray_drains);
    int unsigned n;
    logic [7:0] v;
    n = sb.width * sb.height * sb.chans;
    for (int i = 0; i < n; i++) begin
      if (stray_drains > 0 && $urandom_range(9) == 0) begin
        send_item(1, 8'($urandom));  // early drain: no output
        stray_drains--;
      end
      v = (style == 1) ? (($urandom_range(1)) ? 8'hFF : 8'h00) : 8'($urandom);
      send_item(0, v);
    end
    for (int i = 0; i < extra_px; i++) send_item(0, 8'($urandom));  // dropped bytes
    while (sb.frame_in) send_item(1, 8'($urandom));
  endtask

  int total_items;

  initial begin
    sb = new();
    sb.init();
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: 1x1 image, kernel 1, then a stray even kernel write
    set_geom(1, 1, 1, 1);
    send_frame(1, 0, 0);
    go_idle();
    write_cfg(imf_pkg::REG_KERNEL, 2);      // ignored
    write_cfg(imf_pkg::REG_KERNEL, 7);
    write_cfg(imf_pkg::REG_WIDTH, 0);       // zero taken as one
    write_cfg(imf_pkg::REG_HEIGHT, 13'h1FFF);
    write_cfg(imf_pkg::REG_HEIGHT, 3);
    write_cfg(imf_pkg::REG_CHANNELS, 7);    // saturates to four
    send_frame(1, 0, 1);
    send_item(0, 8'hFF);           // after reset of frame: starts next one
    send_item(0, 8'h00);
    go_idle();
    write_cfg(imf_pkg::REG_WIDTH, 11'h7FF); // saturates to max width
    write_cfg(imf_pkg::REG_CHANNELS, 0);
    write_cfg(imf_pkg::REG_HEIGHT, 1);
    write_cfg(imf_pkg::REG_KERNEL, 1);
    go_idle();

    total_items = 0;
    for (int ph = 0; total_items < 1050; ph++) begin
      int k, w, h, c;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      k = 2 * $urandom_range(3) + 1;
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      c = $urandom_range(1, 4);
      if (ph == 3) begin k = 7; w = 1; h = 1; c = 4; end
      if (ph == 5) begin k = 7; w = 8; h = 8; c = 1; end
      set_geom(k, w, h, c);
      if (ph == 2) hold_cycles = 3000;  // long hold-off while input keeps coming
      send_frame(0, $urandom_range(2), 2);
      total_items += w * h * c;
      go_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) $display("PASS image_median_filter_top");
    else $display("FAIL image_median_filter_top");
    $finish;
  end
endmodule
